// File: rtl/mgre_pkg.sv
`default_nettype none

package mgre_pkg;

    localparam int BANK_WIDTH  = 16;
    localparam int OFF_W       = 4;
    localparam int BANK_IDX_W  = 5;   // covers banks reached by first_pin + 16 * word_index
    localparam int BASE_W      = 9;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        REQ_SET_OUTPUT = 2'd0,
        REQ_SET_MODE   = 2'd1,
        REQ_GET_INPUT  = 2'd2,
        REQ_SAMPLE     = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        MODE_DISABLED  = 3'd0,
        MODE_INPUT     = 3'd1,
        MODE_PUSHPULL  = 3'd2,
        MODE_PULLUP    = 3'd3,
        MODE_PULLDOWN  = 3'd4,
        MODE_OPENDRAIN = 3'd5
    } pin_mode_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_MODE  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_OUT    = 3'd1,
        OP_MODE   = 3'd2,
        OP_READ   = 3'd3,
        OP_SAMPLE = 3'd4
    } op_kind_t;

    // one classified item as it travels from front to back
    typedef struct packed {
        op_kind_t                kind;
        status_t                 status;
        logic [2:0]              mode;
        logic [BANK_IDX_W-1:0]   bank_lo;
        logic [OFF_W-1:0]        off;
        logic [BANK_WIDTH-1:0]   valid_word;
        logic [2*BANK_WIDTH-1:0] valid_sp;
        logic [2*BANK_WIDTH-1:0] set_sp;
        logic [2*BANK_WIDTH-1:0] clr_sp;
        logic [3:0]              sample_bank;
        logic [BANK_WIDTH-1:0]   levels;
    } op_t;

endpackage

`default_nettype wire

// File: rtl/mgre_front.sv
`default_nettype none

module mgre_front #(
    parameter int NUM_BANKS = 10
) (
    input  wire logic [1:0]        req_type,
    input  wire logic [7:0]        first_pin,
    input  wire logic [7:0]        last_pin,
    input  wire logic [3:0]        word_index,
    input  wire logic [15:0]       set_word,
    input  wire logic [15:0]       clear_word,
    input  wire logic [2:0]        pin_mode,
    input  wire logic [3:0]        sample_bank,
    input  wire logic [15:0]       pin_levels,
    output mgre_pkg::op_t          op
);

    localparam logic [mgre_pkg::BASE_W-1:0] PIN_LIMIT =
        mgre_pkg::BASE_W'(NUM_BANKS * mgre_pkg::BANK_WIDTH);
    localparam logic [4:0] BANK_LIMIT = 5'(NUM_BANKS);

    logic [mgre_pkg::BASE_W-1:0]    base;
    logic                           range_bad;
    logic                           sample_bad;
    logic [mgre_pkg::BANK_WIDTH-1:0] valid_word;
    mgre_pkg::req_t                 req;

    assign req  = mgre_pkg::req_t'(req_type);
    assign base = mgre_pkg::BASE_W'(first_pin) + {1'b0, word_index, 4'b0000};

    assign range_bad  = ({1'b0, last_pin} >= PIN_LIMIT) || (first_pin > last_pin);
    assign sample_bad = ({1'b0, sample_bank} >= BANK_LIMIT);

    // bit j is live when its pin does not pass last_pin
    always_comb
    begin
        for (int j = 0; j < mgre_pkg::BANK_WIDTH; j++)
        begin
            valid_word[j] = (10'(base) + 10'(j)) <= 10'(last_pin);
        end
    end

    always_comb
    begin
        op             = '0;
        op.mode        = pin_mode;
        op.bank_lo     = base[mgre_pkg::BASE_W-1:mgre_pkg::OFF_W];
        op.off         = base[mgre_pkg::OFF_W-1:0];
        op.valid_word  = valid_word;
        op.valid_sp    = 32'({16'h0000, valid_word}) << base[mgre_pkg::OFF_W-1:0];
        op.set_sp      = 32'({16'h0000, set_word}) << base[mgre_pkg::OFF_W-1:0];
        op.clr_sp      = 32'({16'h0000, clear_word}) << base[mgre_pkg::OFF_W-1:0];
        op.sample_bank = sample_bank;
        op.levels      = pin_levels;
        op.status      = mgre_pkg::STATUS_OK;
        op.kind        = mgre_pkg::OP_NONE;
        if (req == mgre_pkg::REQ_SAMPLE)
        begin
            if (sample_bad)
            begin
                op.status = mgre_pkg::STATUS_RANGE;
            end
            else
            begin
                op.kind = mgre_pkg::OP_SAMPLE;
            end
        end
        else if (range_bad)
        begin
            op.status = mgre_pkg::STATUS_RANGE;
        end
        else
        begin
            unique case (req)
                mgre_pkg::REQ_SET_OUTPUT: op.kind = mgre_pkg::OP_OUT;
                mgre_pkg::REQ_SET_MODE:   op.kind = mgre_pkg::OP_MODE;
                mgre_pkg::REQ_GET_INPUT:  op.kind = mgre_pkg::OP_READ;
                default:                  op.kind = mgre_pkg::OP_NONE;
            endcase
            // unsupported mode still clears analog select, so it stays an OP_MODE
            if (req == mgre_pkg::REQ_SET_MODE && pin_mode > 3'(mgre_pkg::MODE_OPENDRAIN))
            begin
                op.status = mgre_pkg::STATUS_MODE;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/mgre_queue.sv
`default_nettype none

module mgre_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire mgre_pkg::op_t  push_op,
    output logic                full,
    input  wire logic           pop,
    output logic                not_empty,
    output mgre_pkg::op_t       head
);

    mgre_pkg::op_t                 entry_reg [mgre_pkg::QUEUE_DEPTH];
    logic [mgre_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [mgre_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [mgre_pkg::QCNT_W-1:0]   count_reg, count_next;

    assign full      = (count_reg == mgre_pkg::QCNT_W'(mgre_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == mgre_pkg::QPTR_W'(mgre_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == mgre_pkg::QPTR_W'(mgre_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

// File: rtl/mgre_back.sv
`default_nettype none

module mgre_back #(
    parameter int NUM_BANKS = 10
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           op_valid,
    input  wire mgre_pkg::op_t  head,
    output logic                pop,
    output logic                res_valid,
    input  wire logic           res_ready,
    output logic [1:0]          res_status,
    output logic [15:0]         res_word
);

    localparam int BW = mgre_pkg::BANK_WIDTH;

    logic [BW-1:0] out_latch_reg     [NUM_BANKS];
    logic [BW-1:0] dir_input_reg     [NUM_BANKS];
    logic [BW-1:0] pull_up_en_reg    [NUM_BANKS];
    logic [BW-1:0] pull_down_en_reg  [NUM_BANKS];
    logic [BW-1:0] open_drain_en_reg [NUM_BANKS];
    logic [BW-1:0] analog_sel_reg    [NUM_BANKS];
    logic [BW-1:0] sampled_level_reg [NUM_BANKS];

    logic [2*BW-1:0] lane_gather [NUM_BANKS];
    logic [2*BW-1:0] gathered;
    logic [2*BW-1:0] aligned;
    logic [BW-1:0]   read_word;

    logic            res_valid_reg, res_valid_next;
    logic [1:0]      res_status_reg;
    logic [BW-1:0]   res_word_reg;

    // per-mode targets for the configuration bits
    logic            mode_known;
    logic            dir_v, pu_v, pd_v, od_v, od_touch;

    assign pop = op_valid && (!res_valid_reg || res_ready);

    always_comb
    begin
        mode_known = 1'b1;
        dir_v      = 1'b1;
        pu_v       = 1'b0;
        pd_v       = 1'b0;
        od_v       = 1'b0;
        od_touch   = 1'b1;
        unique case (mgre_pkg::pin_mode_t'(head.mode))
            mgre_pkg::MODE_DISABLED,
            mgre_pkg::MODE_INPUT:
            begin
                od_touch = 1'b0;
            end
            mgre_pkg::MODE_PUSHPULL:
            begin
                dir_v = 1'b0;
            end
            mgre_pkg::MODE_PULLUP:
            begin
                pu_v = 1'b1;
            end
            mgre_pkg::MODE_PULLDOWN:
            begin
                pd_v = 1'b1;
            end
            mgre_pkg::MODE_OPENDRAIN:
            begin
                dir_v = 1'b0;
                od_v  = 1'b1;
            end
            default:
            begin
                mode_known = 1'b0;
            end
        endcase
    end

    for (genvar b = 0; b < NUM_BANKS; b++)
    begin : g_bank
        logic          hit_lo, hit_hi;
        logic [BW-1:0] vm, sm, cm, msel;
        logic          do_out, do_mode, do_cfg, do_sample;
        logic [BW-1:0] latch_new;

        assign hit_lo = (head.bank_lo == mgre_pkg::BANK_IDX_W'(b));
        assign hit_hi = (head.bank_lo == mgre_pkg::BANK_IDX_W'(b) - 1'b1);

        // low half of the spread word lands in bank_lo, high half in the next bank
        assign vm = hit_lo ? head.valid_sp[BW-1:0] : (hit_hi ? head.valid_sp[2*BW-1:BW] : '0);
        assign sm = hit_lo ? head.set_sp[BW-1:0]   : (hit_hi ? head.set_sp[2*BW-1:BW]   : '0);
        assign cm = hit_lo ? head.clr_sp[BW-1:0]   : (hit_hi ? head.clr_sp[2*BW-1:BW]   : '0);
        assign msel = vm & sm;

        assign do_out    = pop && (head.kind == mgre_pkg::OP_OUT);
        assign do_mode   = pop && (head.kind == mgre_pkg::OP_MODE);
        assign do_cfg    = do_mode && mode_known;
        assign do_sample = pop && (head.kind == mgre_pkg::OP_SAMPLE) &&
                           (head.sample_bank == 4'(b));

        // set+clear sets, set alone toggles, neither clears, clear alone keeps
        assign latch_new = (sm & cm) | (sm & ~cm & ~out_latch_reg[b]) |
                           (~sm & cm & out_latch_reg[b]);

        assign lane_gather[b] = hit_lo ? {16'h0000, sampled_level_reg[b]} :
                                (hit_hi ? {sampled_level_reg[b], 16'h0000} : '0);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                out_latch_reg[b]     <= '0;
                dir_input_reg[b]     <= '1;
                pull_up_en_reg[b]    <= '0;
                pull_down_en_reg[b]  <= '0;
                open_drain_en_reg[b] <= '0;
                analog_sel_reg[b]    <= '1;
                sampled_level_reg[b] <= '0;
            end
            else
            begin
                if (do_out)
                begin
                    out_latch_reg[b] <= (out_latch_reg[b] & ~vm) | (latch_new & vm);
                end
                if (do_mode)
                begin
                    analog_sel_reg[b] <= analog_sel_reg[b] & ~msel;
                end
                if (do_cfg)
                begin
                    dir_input_reg[b]    <= (dir_input_reg[b] & ~msel) | (msel & {BW{dir_v}});
                    pull_up_en_reg[b]   <= (pull_up_en_reg[b] & ~msel) | (msel & {BW{pu_v}});
                    pull_down_en_reg[b] <= (pull_down_en_reg[b] & ~msel) |
                                           (msel & {BW{pd_v}});
                    if (od_touch)
                    begin
                        open_drain_en_reg[b] <= (open_drain_en_reg[b] & ~msel) |
                                                (msel & {BW{od_v}});
                    end
                end
                if (do_sample)
                begin
                    sampled_level_reg[b] <= head.levels;
                end
            end
        end
    end

    always_comb
    begin
        gathered = '0;
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            gathered = gathered | lane_gather[b];
        end
    end

    assign aligned   = gathered >> head.off;
    assign read_word = (head.kind == mgre_pkg::OP_READ) ? (aligned[BW-1:0] & head.valid_word) :
                       '0;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (pop)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_status_reg <= head.status;
            res_word_reg   <= read_word;
        end
    end

    assign res_valid  = res_valid_reg;
    assign res_status = res_status_reg;
    assign res_word   = res_word_reg;

    a_word_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.kind != mgre_pkg::OP_READ) |=> (res_word == '0))
        else $error("read word nonzero for a request that is not a read");

    a_range_err_no_op: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.status == mgre_pkg::STATUS_RANGE) |-> (head.kind == mgre_pkg::OP_NONE))
        else $error("range error item would change bank state");

    a_pop_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (res_valid && res_status == $past(head.status)))
        else $error("popped item did not reach the result register");

endmodule

`default_nettype wire

// File: rtl/multibank_gpio_range_engine_unit.sv
`default_nettype none

// gpio range engine over NUM_BANKS banks of 16 pins
// input channel s_axis: one request item per handshake; tuser carries the request
// type (set output, set mode, get input, sample one bank's pin levels), tdata the
// pin range, mask word and payload
// output channel m_axis: exactly one result item per request, in request order;
// tuser is the status (ok, range error, unsupported mode), tdata the aligned read word
// a classifier registers each request into a two-entry queue; the bank unit pops it,
// updates the bank registers and loads the result register
// throughput: one item per cycle while m_axis does not stall; every request touches
// at most two adjacent banks
// reset: all banks go to inputs with analog select on, latches, pulls and sampled
// levels clear; queue and result register empty
// when m_axis stalls the result register holds, the queue fills, and s_axis tready
// drops once both queue entries are taken
module multibank_gpio_range_engine_unit #(
    parameter int NUM_BANKS = 10
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // first_pin, last_pin, word_index, set_word, clear_word, pin_mode, sample_bank,
    // pin_levels, zero pad
    input  wire logic [79:0] s_axis_tdata,
    // req_type
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // read_word
    output logic [15:0]      m_axis_tdata,
    // status
    output logic [1:0]       m_axis_tuser
);

    mgre_pkg::op_t in_op;
    mgre_pkg::op_t head;
    logic          queue_full;
    logic          queue_not_empty;
    logic          push;
    logic          pop;

    assign s_axis_tready = !queue_full;
    assign push          = s_axis_tvalid && !queue_full;

    mgre_front #(
        .NUM_BANKS (NUM_BANKS)
    ) u_front (
        .req_type    (s_axis_tuser),
        .first_pin   (s_axis_tdata[7:0]),
        .last_pin    (s_axis_tdata[15:8]),
        .word_index  (s_axis_tdata[19:16]),
        .set_word    (s_axis_tdata[35:20]),
        .clear_word  (s_axis_tdata[51:36]),
        .pin_mode    (s_axis_tdata[54:52]),
        .sample_bank (s_axis_tdata[58:55]),
        .pin_levels  (s_axis_tdata[74:59]),
        .op          (in_op)
    );

    mgre_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_op   (in_op),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .head      (head)
    );

    mgre_back #(
        .NUM_BANKS (NUM_BANKS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_valid   (queue_not_empty),
        .head       (head),
        .pop        (pop),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res_status (m_axis_tuser),
        .res_word   (m_axis_tdata)
    );

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BANKS  = 10;
    localparam int NUM_PINS   = NUM_BANKS * mgre_pkg::BANK_WIDTH;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_LEN   = 120;

    // request item as it sits on the bus: req_type in tuser, the rest in tdata
    typedef struct packed {
        mgre_pkg::req_t req;
        logic [15:0]    pin_levels;
        logic [3:0]     sample_bank;
        logic [2:0]     pin_mode;
        logic [15:0]    clear_word;
        logic [15:0]    set_word;
        logic [3:0]     word_index;
        logic [7:0]     last_pin;
        logic [7:0]     first_pin;
    } gpio_req_s;

    localparam int REQ_W = $bits(gpio_req_s);

    class gpio_scoreboard;
        logic [15:0]        out_latch[NUM_BANKS];
        logic [15:0]        dir_in[NUM_BANKS];
        logic [15:0]        pull_up[NUM_BANKS];
        logic [15:0]        pull_down[NUM_BANKS];
        logic [15:0]        open_drain[NUM_BANKS];
        logic [15:0]        analog[NUM_BANKS];
        logic [15:0]        sampled[NUM_BANKS];
        mgre_pkg::status_t  exp_status[$];
        logic [15:0]        exp_word[$];
        int unsigned        errors;

        function new();
            for (int b = 0; b < NUM_BANKS; b++)
            begin
                out_latch[b]  = '0;
                dir_in[b]     = '1;
                pull_up[b]    = '0;
                pull_down[b]  = '0;
                open_drain[b] = '0;
                analog[b]     = '1;
                sampled[b]    = '0;
            end
            errors = 0;
        endfunction

        function int pending();
            return exp_status.size();
        endfunction

        function void set_pin_mode(int b, int i, logic [2:0] mode);
            analog[b][i] = 1'b0;
            case (mode)
                mgre_pkg::MODE_DISABLED, mgre_pkg::MODE_INPUT:
                begin
                    dir_in[b][i]    = 1'b1;
                    pull_up[b][i]   = 1'b0;
                    pull_down[b][i] = 1'b0;
                end
                mgre_pkg::MODE_PUSHPULL:
                begin
                    dir_in[b][i]     = 1'b0;
                    pull_up[b][i]    = 1'b0;
                    pull_down[b][i]  = 1'b0;
                    open_drain[b][i] = 1'b0;
                end
                mgre_pkg::MODE_PULLUP:
                begin
                    dir_in[b][i]     = 1'b1;
                    pull_up[b][i]    = 1'b1;
                    pull_down[b][i]  = 1'b0;
                    open_drain[b][i] = 1'b0;
                end
                mgre_pkg::MODE_PULLDOWN:
                begin
                    dir_in[b][i]     = 1'b1;
                    pull_up[b][i]    = 1'b0;
                    pull_down[b][i]  = 1'b1;
                    open_drain[b][i] = 1'b0;
                end
                mgre_pkg::MODE_OPENDRAIN:
                begin
                    dir_in[b][i]     = 1'b0;
                    pull_up[b][i]    = 1'b0;
                    pull_down[b][i]  = 1'b0;
                    open_drain[b][i] = 1'b1;
                end
                default:
                begin
                end
            endcase
        endfunction

        function void note_input(gpio_req_s r);
            mgre_pkg::status_t st;
            logic [15:0]       rd;
            int                base;
            int                p;
            int                b;
            int                i;
            logic              s;
            logic              c;
            logic              x;
            st = mgre_pkg::STATUS_OK;
            rd = '0;
            if (r.req == mgre_pkg::REQ_SAMPLE)
            begin
                if (int'(r.sample_bank) < NUM_BANKS)
                    sampled[r.sample_bank] = r.pin_levels;
                else
                    st = mgre_pkg::STATUS_RANGE;
            end
            else if (int'(r.last_pin) >= NUM_PINS || r.first_pin > r.last_pin)
            begin
                st = mgre_pkg::STATUS_RANGE;
            end
            else
            begin
                base = int'(r.first_pin) + mgre_pkg::BANK_WIDTH * int'(r.word_index);
                for (int j = 0; j < mgre_pkg::BANK_WIDTH; j++)
                begin
                    p = base + j;
                    if (p > int'(r.last_pin))
                        break;
                    b = p / mgre_pkg::BANK_WIDTH;
                    i = p % mgre_pkg::BANK_WIDTH;
                    case (r.req)
                        mgre_pkg::REQ_SET_OUTPUT:
                        begin
                            s = r.set_word[j];
                            c = r.clear_word[j];
                            x = out_latch[b][i];
                            out_latch[b][i] = s ? (c ? 1'b1 : ~x) : (c ? x : 1'b0);
                        end
                        mgre_pkg::REQ_SET_MODE:
                        begin
                            if (r.set_word[j])
                                set_pin_mode(b, i, r.pin_mode);
                        end
                        default:
                            rd[j] = sampled[b][i];
                    endcase
                end
                if (r.req == mgre_pkg::REQ_SET_MODE &&
                    r.pin_mode > 3'(mgre_pkg::MODE_OPENDRAIN))
                    st = mgre_pkg::STATUS_MODE;
            end
            exp_status.push_back(st);
            exp_word.push_back(rd);
        endfunction

        function void check_result(mgre_pkg::status_t st, logic [15:0] rd);
            mgre_pkg::status_t want_st;
            logic [15:0]       want_rd;
            if (exp_status.size() == 0)
            begin
                $error("result item with nothing expected: status %0d read_word %h", st, rd);
                errors++;
                return;
            end
            want_st = exp_status.pop_front();
            want_rd = exp_word.pop_front();
            if (st !== want_st)
            begin
                $error("status mismatch: expected %0d, actual %0d", want_st, st);
                errors++;
            end
            if (rd !== want_rd)
            begin
                $error("read_word mismatch: expected %h, actual %h", want_rd, rd);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    gpio_scoreboard sb;
    bit             no_idle   = 1'b0;
    bit             hold_sink = 1'b0;
    int unsigned    idle_cycles = 0;

    multibank_gpio_range_engine_unit #(
        .NUM_BANKS(NUM_BANKS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic gpio_req_s mk_req(mgre_pkg::req_t req, int first, int last, int widx,
                                         int setw, int clrw, int mode, int sbank,
                                         int levels);
        gpio_req_s r;
        r.req         = req;
        r.first_pin   = 8'(first);
        r.last_pin    = 8'(last);
        r.word_index  = 4'(widx);
        r.set_word    = 16'(setw);
        r.clear_word  = 16'(clrw);
        r.pin_mode    = 3'(mode);
        r.sample_bank = 4'(sbank);
        r.pin_levels  = 16'(levels);
        return r;
    endfunction

    // mostly legal ranges and banks with random payload, about one in ten pure noise
    function automatic gpio_req_s random_req();
        gpio_req_s r;
        int        span;
        r = gpio_req_s'(REQ_W'({$urandom, $urandom, $urandom}));
        if ($urandom_range(0, 9) != 0)
        begin
            if (r.req == mgre_pkg::REQ_SAMPLE)
            begin
                r.sample_bank = 4'($urandom_range(0, NUM_BANKS - 1));
            end
            else
            begin
                r.first_pin = 8'($urandom_range(0, NUM_PINS - 1));
                if ($urandom_range(0, 1) == 0)
                    r.last_pin = 8'($urandom_range(r.first_pin, NUM_PINS - 1));
                else
                    r.last_pin = 8'($urandom_range(r.first_pin,
                                                   (r.first_pin + 24 < NUM_PINS) ?
                                                   r.first_pin + 24 : NUM_PINS - 1));
                span = (int'(r.last_pin) - int'(r.first_pin)) / mgre_pkg::BANK_WIDTH;
                if ($urandom_range(0, 7) != 0)
                    r.word_index = 4'($urandom_range(0, span));
                if ($urandom_range(0, 7) != 0)
                    r.pin_mode = 3'($urandom_range(0, 5));
            end
        end
        return r;
    endfunction

    task automatic send_item(gpio_req_s r);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, r[74:0]};
        s_axis_tuser  <= r.req;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic send_directed();
        // reads at reset, sampling incl. banks past the top
        send_item(mk_req(mgre_pkg::REQ_GET_INPUT, 0, 15, 0, 0, 0, 0, 0, 0));
        send_item(mk_req(mgre_pkg::REQ_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 'ha5a5));
        send_item(mk_req(mgre_pkg::REQ_SAMPLE, 0, 0, 0, 0, 0, 0, 8, 'h1234));
        send_item(mk_req(mgre_pkg::REQ_SAMPLE, 0, 0, 0, 0, 0, 0, 9, 'hffff));
        send_item(mk_req(mgre_pkg::REQ_SAMPLE, 0, 0, 0, 0, 0, 0, 10, 'hffff));
        send_item(mk_req(mgre_pkg::REQ_SAMPLE, 255, 255, 15, 'hffff, 'hffff, 7, 15, 0));
        send_item(mk_req(mgre_pkg::REQ_GET_INPUT, 0, 15, 0, 0, 0, 0, 0, 0));
        // window across banks 8 and 9, then the partial second word
        send_item(mk_req(mgre_pkg::REQ_GET_INPUT, 140, 159, 0, 0, 0, 0, 0, 0));
        send_item(mk_req(mgre_pkg::REQ_GET_INPUT, 140, 159, 1, 0, 0, 0, 0, 0));
        // set all, then every set/clear combination
        send_item(mk_req(mgre_pkg::REQ_SET_OUTPUT, 0, 159, 0, 'hffff, 'hffff, 0, 0, 0));
        send_item(mk_req(mgre_pkg::REQ_SET_OUTPUT, 4, 159, 0, 'hff00, 'h0f0f, 0, 0, 0));
        send_item(mk_req(mgre_pkg::REQ_SET_OUTPUT, 150, 159, 0, 0, 0, 0, 0, 0));
        // range past the pins, reversed range
        send_item(mk_req(mgre_pkg::REQ_SET_OUTPUT, 0, 255, 0, 'hffff, 0, 0, 0, 0));
        send_item(mk_req(mgre_pkg::REQ_GET_INPUT, 3, 160, 0, 0, 0, 0, 0, 0));
        send_item(mk_req(mgre_pkg::REQ_SET_MODE, 255, 0, 0, 'hffff, 0, 2, 0, 0));
        // word wholly past the range
        send_item(mk_req(mgre_pkg::REQ_SET_OUTPUT, 0, 15, 15, 0, 0, 0, 0, 0));
        send_item(mk_req(mgre_pkg::REQ_GET_INPUT, 0, 15, 15, 0, 0, 0, 0, 0));
        // every mode, the unsupported two last
        for (int m = 0; m < 8; m++)
            send_item(mk_req(mgre_pkg::REQ_SET_MODE, 2 * m + 7, 159, m % 3,
                             (m % 2 == 0) ? 'hffff : 'h5a5a, 0, m, 0, 0));
    endtask

    initial
    begin : stimulus
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_directed();
        for (int n = 0; n < 550; n++)
        begin
            no_idle = (n >= 200 && n < 300);
            if (n == 350)
                hold_sink = 1'b1;
            send_item(random_req());
        end
        s_axis_tvalid <= 1'b0;
        // let the monitor note the last accepted item first
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : sink
        int unsigned gap;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_sink)
            begin
                // long back-pressure so the queue fills and tready drops
                m_axis_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
                hold_sink = 1'b0;
            end
            gap = no_idle ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_input(gpio_req_s'({s_axis_tuser, s_axis_tdata[74:0]}));
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(mgre_pkg::status_t'(m_axis_tuser), m_axis_tdata);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule

`default_nettype wire
